// File: rtl/cuc_pkg.sv
// ----------------------------------------------------------------------------
// Crossover upward compressor: shared definitions
// Sample format, register map, reset values, lane command and status types
// and the fixed-point constants used by the channel lanes.
// ----------------------------------------------------------------------------
package cuc_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int CHANNELS    = 2;
	localparam int GUARD       = 32 - SAMPLE_BITS;

	localparam int COEFF_W     = 25;
	localparam int THRESH_W    = 23;
	localparam int SLOPE_W     = 24;
	localparam int CEIL_W      = 23;
	localparam int CFG_DATA_W  = 25;
	localparam int CFG_INDEX_W = 3;

	localparam int STATE_W     = 32;
	localparam int HIGH_W      = STATE_W + 1;
	localparam int MUL_A_W     = STATE_W + 2;
	localparam int MUL_B_W     = 32;
	localparam int PROD_W      = MUL_A_W + MUL_B_W + 1;
	localparam int SUM_W       = 48;
	localparam int GAIN_W      = 32;
	localparam int THRW_W      = THRESH_W + 8;

	localparam int COEFF_FRAC  = 24;
	localparam int SLOPE_SHIFT = 25;
	localparam int GAIN_FRAC   = 20;

	localparam int GUARD_M1    = (GUARD > 0) ? GUARD - 1 : 0;
	localparam int CEIL_UP     = (SAMPLE_BITS >= 24) ? SAMPLE_BITS - 24 : 0;
	localparam int CEIL_DOWN   = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;

	localparam logic signed [PROD_W-1:0] HALF_COEFF = PROD_W'(1) <<< (COEFF_FRAC - 1);
	localparam logic signed [PROD_W-1:0] HALF_SLOPE = PROD_W'(1) <<< (SLOPE_SHIFT - 1);
	localparam logic signed [PROD_W-1:0] HALF_GAIN  = PROD_W'(1) <<< (GAIN_FRAC - 1);
	localparam logic signed [SUM_W-1:0]  OUT_RND    =
		(GUARD > 0) ? (SUM_W'(1) <<< GUARD_M1) : SUM_W'(0);

	localparam logic signed [SUM_W-1:0] LOW_MAX = (SUM_W'(1) <<< (STATE_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] LOW_MIN = -(SUM_W'(1) <<< (STATE_W - 1));
	localparam logic signed [SUM_W-1:0] ENV_MAX = (SUM_W'(1) <<< STATE_W) - SUM_W'(1);
	localparam logic [GAIN_W-1:0]       GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

	localparam logic [COEFF_W-1:0]  RST_CROSSOVER = COEFF_W'(4320427);
	localparam logic [COEFF_W-1:0]  RST_ATTACK    = COEFF_W'(16777216);
	localparam logic [COEFF_W-1:0]  RST_RELEASE   = COEFF_W'(34945);
	localparam logic [THRESH_W-1:0] RST_THRESHOLD = THRESH_W'(167772);
	localparam logic [SLOPE_W-1:0]  RST_SLOPE     = SLOPE_W'(0);
	localparam logic [CEIL_W-1:0]   RST_CEILING   = CEIL_W'(8288025);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ENABLE,
		REG_STEREO,
		REG_CROSSOVER,
		REG_ATTACK,
		REG_RELEASE,
		REG_THRESHOLD,
		REG_SLOPE,
		REG_CEILING
	} reg_index_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [COEFF_W-1:0]  crossover_coeff;
		logic [COEFF_W-1:0]  attack_coeff;
		logic [COEFF_W-1:0]  release_coeff;
		logic [THRESH_W-1:0] quiet_threshold;
		logic [SLOPE_W-1:0]  boost_slope;
		logic [CEIL_W-1:0]   ceiling;
	} lane_cfg_t;

	typedef struct packed {
		logic    start;
		logic    run;
		logic    clear;
		sample_t x;
	} lane_cmd_t;

	typedef struct packed {
		logic    busy;
		sample_t y;
	} lane_status_t;

	function automatic logic [SAMPLE_BITS-1:0] scale_ceiling(input logic [CEIL_W-1:0] c);
		logic [STATE_W-1:0] wide;
		wide = STATE_W'(c);
		wide = (wide << CEIL_UP) >> CEIL_DOWN;
		return wide[SAMPLE_BITS-1:0];
	endfunction

endpackage

// File: rtl/cuc_sample_if.sv
// ----------------------------------------------------------------------------
// Crossover upward compressor: sample channel
// Valid/ready channel carrying one stereo sample pair and a block start flag.
// ----------------------------------------------------------------------------
interface cuc_sample_if;

	logic             valid;
	logic             ready;
	cuc_pkg::sample_t sample_left;
	cuc_pkg::sample_t sample_right;
	logic             block_start;

	modport source(output valid, sample_left, sample_right, block_start, input ready);
	modport sink(input valid, sample_left, sample_right, block_start, output ready);

endinterface

// File: rtl/cuc_result_if.sv
// ----------------------------------------------------------------------------
// Crossover upward compressor: result channel
// Valid/ready channel carrying one processed stereo sample pair.
// ----------------------------------------------------------------------------
interface cuc_result_if;

	logic             valid;
	logic             ready;
	cuc_pkg::sample_t out_left;
	cuc_pkg::sample_t out_right;

	modport source(output valid, out_left, out_right, input ready);
	modport sink(input valid, out_left, out_right, output ready);

endinterface

// File: rtl/cuc_lane.sv
// ----------------------------------------------------------------------------
// Crossover upward compressor: channel lane
// Processes one channel through crossover, envelope, gain and clip steps,
// sharing a single multiplier with a registered product between steps.
// ----------------------------------------------------------------------------
module cuc_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cuc_pkg::lane_cfg_t    cfg,
	input  cuc_pkg::lane_cmd_t    cmd,
	output cuc_pkg::lane_status_t status
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LP_MUL,
		ST_LP_ACC,
		ST_ENV_MUL,
		ST_ENV_ACC,
		ST_GAIN_MUL,
		ST_GAIN_ACC,
		ST_BOOST_MUL,
		ST_OUT
	} state_t;

	state_t                                 state_q;
	cuc_pkg::sample_t                       x_q;
	cuc_pkg::sample_t                       y_q;
	logic signed [cuc_pkg::STATE_W-1:0]     low_q;
	logic [cuc_pkg::STATE_W-1:0]            env_q;
	logic signed [cuc_pkg::HIGH_W-1:0]      high_q;
	logic [cuc_pkg::GAIN_W-1:0]             gain_q;
	logic                                   boost_q;
	logic signed [cuc_pkg::PROD_W-1:0]      prod_q;

	logic signed [cuc_pkg::STATE_W-1:0]     xw;
	logic signed [cuc_pkg::HIGH_W-1:0]      high_now;
	logic [cuc_pkg::HIGH_W-1:0]             mag;
	logic signed [cuc_pkg::MUL_A_W-1:0]     mag_s;
	logic signed [cuc_pkg::MUL_A_W-1:0]     env_s;
	logic signed [cuc_pkg::MUL_A_W-1:0]     thr_s;
	logic [cuc_pkg::THRW_W-1:0]             thrw;
	logic                                   grow;
	logic                                   boost_now;
	logic signed [cuc_pkg::MUL_A_W-1:0]     mul_a;
	logic [cuc_pkg::MUL_B_W-1:0]            mul_b;
	logic signed [cuc_pkg::PROD_W-1:0]      prod;
	logic signed [cuc_pkg::PROD_W-1:0]      rnd_coeff;
	logic signed [cuc_pkg::PROD_W-1:0]      rnd_slope;
	logic signed [cuc_pkg::PROD_W-1:0]      rnd_gain;
	logic signed [cuc_pkg::SUM_W-1:0]       low_sum;
	logic signed [cuc_pkg::STATE_W-1:0]     low_next;
	logic signed [cuc_pkg::SUM_W-1:0]       env_sum;
	logic [cuc_pkg::STATE_W-1:0]            env_next;
	logic [cuc_pkg::GAIN_W-1:0]             gain_next;
	logic signed [cuc_pkg::SUM_W-1:0]       out_sum;
	logic signed [cuc_pkg::SUM_W-1:0]       out_rnd;
	logic [cuc_pkg::SAMPLE_BITS-1:0]        ceil_mag;
	logic signed [cuc_pkg::SUM_W-1:0]       ceil_pos;
	logic signed [cuc_pkg::SUM_W-1:0]       ceil_neg;
	logic signed [cuc_pkg::SUM_W-1:0]       out_clip;

	always_comb begin
		xw        = cuc_pkg::STATE_W'(x_q) <<< cuc_pkg::GUARD;
		high_now  = cuc_pkg::HIGH_W'(xw) - cuc_pkg::HIGH_W'(low_q);
		mag       = high_now[cuc_pkg::HIGH_W-1] ? cuc_pkg::HIGH_W'(-high_now)
		                                        : cuc_pkg::HIGH_W'(high_now);
		mag_s     = cuc_pkg::MUL_A_W'({1'b0, mag});
		env_s     = cuc_pkg::MUL_A_W'({1'b0, env_q});
		thrw      = {cfg.quiet_threshold, 8'b0};
		thr_s     = cuc_pkg::MUL_A_W'({1'b0, thrw});
		grow      = mag > cuc_pkg::HIGH_W'(env_q);
		boost_now = cuc_pkg::STATE_W'(thrw) > env_q;
	end

	always_comb begin
		case (state_q)
			ST_LP_MUL: begin
				mul_a = cuc_pkg::MUL_A_W'(xw) - cuc_pkg::MUL_A_W'(low_q);
				mul_b = cuc_pkg::MUL_B_W'(cfg.crossover_coeff);
			end
			ST_ENV_MUL: begin
				mul_a = mag_s - env_s;
				mul_b = grow ? cuc_pkg::MUL_B_W'(cfg.attack_coeff)
				             : cuc_pkg::MUL_B_W'(cfg.release_coeff);
			end
			ST_GAIN_MUL: begin
				mul_a = thr_s - env_s;
				mul_b = cuc_pkg::MUL_B_W'(cfg.boost_slope);
			end
			ST_BOOST_MUL: begin
				mul_a = cuc_pkg::MUL_A_W'(high_q);
				mul_b = gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = cuc_pkg::PROD_W'(mul_a) * cuc_pkg::PROD_W'(signed'({1'b0, mul_b}));
	end

	always_comb begin
		rnd_coeff = (prod_q + cuc_pkg::HALF_COEFF) >>> cuc_pkg::COEFF_FRAC;
		rnd_slope = (prod_q + cuc_pkg::HALF_SLOPE) >>> cuc_pkg::SLOPE_SHIFT;
		rnd_gain  = (prod_q + cuc_pkg::HALF_GAIN) >>> cuc_pkg::GAIN_FRAC;

		low_sum = cuc_pkg::SUM_W'(rnd_coeff) + cuc_pkg::SUM_W'(low_q);
		if (low_sum > cuc_pkg::LOW_MAX) begin
			low_next = cuc_pkg::STATE_W'(cuc_pkg::LOW_MAX);
		end else if (low_sum < cuc_pkg::LOW_MIN) begin
			low_next = cuc_pkg::STATE_W'(cuc_pkg::LOW_MIN);
		end else begin
			low_next = signed'(low_sum[cuc_pkg::STATE_W-1:0]);
		end

		env_sum = cuc_pkg::SUM_W'(rnd_coeff) + cuc_pkg::SUM_W'(env_s);
		if (env_sum < 0) begin
			env_next = '0;
		end else if (env_sum > cuc_pkg::ENV_MAX) begin
			env_next = '1;
		end else begin
			env_next = env_sum[cuc_pkg::STATE_W-1:0];
		end

		gain_next = boost_q ? cuc_pkg::GAIN_ONE + rnd_slope[cuc_pkg::GAIN_W-1:0]
		                    : cuc_pkg::GAIN_ONE;

		out_sum  = cuc_pkg::SUM_W'(rnd_gain) + cuc_pkg::SUM_W'(low_q);
		out_rnd  = (out_sum + cuc_pkg::OUT_RND) >>> cuc_pkg::GUARD;
		ceil_mag = cuc_pkg::scale_ceiling(cfg.ceiling);
		ceil_pos = cuc_pkg::SUM_W'({1'b0, ceil_mag});
		ceil_neg = -ceil_pos;
		if (out_rnd > ceil_pos) begin
			out_clip = ceil_pos;
		end else if (out_rnd < ceil_neg) begin
			out_clip = ceil_neg;
		end else begin
			out_clip = out_rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			low_q   <= '0;
			env_q   <= '0;
			y_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						if (cmd.clear) begin
							low_q <= '0;
							env_q <= '0;
						end
						if (cmd.run) begin
							state_q <= ST_LP_MUL;
						end else begin
							y_q <= cmd.x;
						end
					end
				end
				ST_LP_MUL:    state_q <= ST_LP_ACC;
				ST_LP_ACC: begin
					low_q   <= low_next;
					state_q <= ST_ENV_MUL;
				end
				ST_ENV_MUL:   state_q <= ST_ENV_ACC;
				ST_ENV_ACC: begin
					env_q   <= env_next;
					state_q <= ST_GAIN_MUL;
				end
				ST_GAIN_MUL:  state_q <= ST_GAIN_ACC;
				ST_GAIN_ACC:  state_q <= ST_BOOST_MUL;
				ST_BOOST_MUL: state_q <= ST_OUT;
				ST_OUT: begin
					y_q     <= out_clip[cuc_pkg::SAMPLE_BITS-1:0];
					state_q <= ST_IDLE;
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;
		if (state_q == ST_IDLE && cmd.start) begin
			x_q <= cmd.x;
		end
		if (state_q == ST_ENV_MUL) begin
			high_q <= high_now;
		end
		if (state_q == ST_GAIN_MUL) begin
			boost_q <= boost_now;
		end
		if (state_q == ST_GAIN_ACC) begin
			gain_q <= gain_next;
		end
	end

	assign status.busy = (state_q != ST_IDLE);
	assign status.y    = y_q;

endmodule

// File: rtl/cuc_merge.sv
// ----------------------------------------------------------------------------
// Crossover upward compressor: merge stage
// Gathers the finished lane samples into the output register and drives
// the result channel.
// ----------------------------------------------------------------------------
module cuc_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 done,
	input  cuc_pkg::sample_t     left_y,
	input  cuc_pkg::sample_t     right_y,
	cuc_result_if.source         result_ch,
	output logic                 load
);

	logic             valid_q;
	cuc_pkg::sample_t left_q;
	cuc_pkg::sample_t right_q;

	assign load = done && (!valid_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q  <= left_y;
			right_q <= right_y;
		end
	end

	assign result_ch.valid     = valid_q;
	assign result_ch.out_left  = left_q;
	assign result_ch.out_right = right_q;

endmodule

// File: rtl/crossover_upward_compressor_core.sv
// ----------------------------------------------------------------------------
// Crossover upward compressor core
// Two-band upward compressor with a one-pole crossover, one lane per channel.
// ----------------------------------------------------------------------------
// A request on sample_ch carries one stereo sample pair and a block start
// flag; a request on result_ch returns the processed pair. Both channels
// use valid/ready and move a request when both are high at a clock edge.
// Registers are written through cfg_write_en, cfg_index and cfg_data; the
// user must write them only while the core is idle, which it does not enforce.
// Each channel has its own lane with one shared multiplier, which takes
// the sample through eight steps: crossover, envelope, gain and clip,
// each split into a multiply and an accumulate. A processed request is
// loaded into the output register once both lanes have finished; a bypassed
// one is copied straight to the lane outputs. The core takes no new request
// until the previous one has been loaded into the output register.
// The output register decouples the two sides, so a new request is taken
// while a result still waits. If the receiver stalls, finished samples
// stay in the lanes and sample_ch holds ready low until they move on.
// Reset clears the filter and envelope state and loads the register
// defaults: processing disabled, stereo selected.
// ----------------------------------------------------------------------------
module crossover_upward_compressor_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [cuc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cuc_pkg::CFG_DATA_W-1:0]    cfg_data,
	cuc_sample_if.sink                        sample_ch,
	cuc_result_if.source                      result_ch
);

	logic                  enable_q;
	logic                  stereo_q;
	cuc_pkg::lane_cfg_t    cfg_q;
	logic                  pending_q;
	logic                  accept;
	logic                  lanes_busy;
	logic                  done;
	logic                  load;
	cuc_pkg::sample_t      right_y;
	cuc_pkg::lane_cmd_t    cmd [cuc_pkg::CHANNELS];
	cuc_pkg::lane_status_t status [cuc_pkg::CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q              <= 1'b0;
			stereo_q              <= 1'b1;
			cfg_q.crossover_coeff <= cuc_pkg::RST_CROSSOVER;
			cfg_q.attack_coeff    <= cuc_pkg::RST_ATTACK;
			cfg_q.release_coeff   <= cuc_pkg::RST_RELEASE;
			cfg_q.quiet_threshold <= cuc_pkg::RST_THRESHOLD;
			cfg_q.boost_slope     <= cuc_pkg::RST_SLOPE;
			cfg_q.ceiling         <= cuc_pkg::RST_CEILING;
		end else if (cfg_write_en) begin
			case (cuc_pkg::reg_index_t'(cfg_index))
				cuc_pkg::REG_ENABLE:    enable_q <= cfg_data[0];
				cuc_pkg::REG_STEREO:    stereo_q <= cfg_data[0];
				cuc_pkg::REG_CROSSOVER: cfg_q.crossover_coeff <= cfg_data[cuc_pkg::COEFF_W-1:0];
				cuc_pkg::REG_ATTACK:    cfg_q.attack_coeff <= cfg_data[cuc_pkg::COEFF_W-1:0];
				cuc_pkg::REG_RELEASE:   cfg_q.release_coeff <= cfg_data[cuc_pkg::COEFF_W-1:0];
				cuc_pkg::REG_THRESHOLD: cfg_q.quiet_threshold <= cfg_data[cuc_pkg::THRESH_W-1:0];
				cuc_pkg::REG_SLOPE:     cfg_q.boost_slope <= cfg_data[cuc_pkg::SLOPE_W-1:0];
				cuc_pkg::REG_CEILING:   cfg_q.ceiling <= cfg_data[cuc_pkg::CEIL_W-1:0];
				default:                enable_q <= enable_q;
			endcase
		end
	end

	assign sample_ch.ready = !pending_q;
	assign accept          = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (accept) begin
			pending_q <= 1'b1;
		end else if (load) begin
			pending_q <= 1'b0;
		end
	end

	for (genvar ch = 0; ch < cuc_pkg::CHANNELS; ch++) begin : g_lane
		assign cmd[ch].start = accept;
		assign cmd[ch].clear = sample_ch.block_start;
		assign cmd[ch].run   = enable_q && ((ch == 0) || stereo_q);
		assign cmd[ch].x     = (ch == 0) ? sample_ch.sample_left : sample_ch.sample_right;

		cuc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_q),
			.cmd    (cmd[ch]),
			.status (status[ch])
		);
	end

	if (cuc_pkg::CHANNELS > 1) begin : g_right_lane
		assign right_y = status[1].y;
	end else begin : g_right_pass
		cuc_pkg::sample_t right_pass_q;

		always_ff @(posedge clk) begin
			if (accept) begin
				right_pass_q <= sample_ch.sample_right;
			end
		end

		assign right_y = right_pass_q;
	end

	always_comb begin
		lanes_busy = 1'b0;
		for (int ch = 0; ch < cuc_pkg::CHANNELS; ch++) begin
			lanes_busy = lanes_busy | status[ch].busy;
		end
	end

	assign done = pending_q && !lanes_busy;

	cuc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.done      (done),
		.left_y    (status[0].y),
		.right_y   (right_y),
		.result_ch (result_ch),
		.load      (load)
	);

	a_lanes_idle_without_request: assert property (
		@(posedge clk) disable iff (!arst_n) !pending_q |-> !lanes_busy
	) else $error("A lane is working while no request is pending.");

	a_accept_marks_pending: assert property (
		@(posedge clk) disable iff (!arst_n) accept |=> pending_q
	) else $error("An accepted request was not held as pending.");

	a_result_from_pending: assert property (
		@(posedge clk) disable iff (!arst_n) $rose(result_ch.valid) |-> $past(pending_q)
	) else $error("A result appeared without a pending request.");

endmodule

// File: test/compressor_checker.sv
// ----------------------------------------------------------------------------
// Crossover upward compressor: result checker
// Watches the register port and both request channels. It predicts each
// processed stereo pair from its own copy of the filter and envelope state,
// and compares every returned pair field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module compressor_checker
	import cuc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	cuc_sample_if                  sample_ch,
	cuc_result_if                  result_ch,
	output int                     mismatches,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		sample_t left;
		sample_t right;
	} pair_t;

	logic                enabled;
	logic                stereo_on;
	logic [COEFF_W-1:0]  xover_k;
	logic [COEFF_W-1:0]  attack_k;
	logic [COEFF_W-1:0]  release_k;
	logic [THRESH_W-1:0] threshold;
	logic [SLOPE_W-1:0]  slope;
	logic [CEIL_W-1:0]   ceil_mag;
	longint              low_band [CHANNELS];
	longint              env_level [CHANNELS];
	pair_t               expected_pairs [$];

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint limit(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic sample_t compress_channel(sample_t x, int ch);
		longint xw, lo, env, high, mag, k, thrw, gain, y, lim;
		xw   = longint'(x) <<< GUARD;
		lo   = low_band[ch];
		env  = env_level[ch];
		lo   = limit(lo + round_shift((xw - lo) * longint'(xover_k), COEFF_FRAC),
			-(longint'(1) <<< (STATE_W - 1)), (longint'(1) <<< (STATE_W - 1)) - 1);
		high = xw - lo;
		mag  = (high < 0) ? -high : high;
		k    = (mag > env) ? longint'(attack_k) : longint'(release_k);
		env  = limit(env + round_shift((mag - env) * k, COEFF_FRAC),
			0, (longint'(1) <<< STATE_W) - 1);
		low_band[ch]  = lo;
		env_level[ch] = env;
		thrw = longint'(threshold) <<< 8;
		if (env < thrw) begin
			gain = (longint'(1) <<< GAIN_FRAC) +
				round_shift((thrw - env) * longint'(slope), SLOPE_SHIFT);
			high = round_shift(high * gain, GAIN_FRAC);
		end
		y   = round_shift(lo + high, GUARD);
		lim = (longint'(ceil_mag) <<< CEIL_UP) >>> CEIL_DOWN;
		return sample_t'(limit(y, -lim, lim));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pair_t want;
		pair_t got;
		if (!arst_n) begin
			enabled     = 1'b0;
			stereo_on   = 1'b1;
			xover_k     = RST_CROSSOVER;
			attack_k    = RST_ATTACK;
			release_k   = RST_RELEASE;
			threshold   = RST_THRESHOLD;
			slope       = RST_SLOPE;
			ceil_mag    = RST_CEILING;
			for (int c = 0; c < CHANNELS; c++) begin
				low_band[c]  = 0;
				env_level[c] = 0;
			end
			expected_pairs.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_write_en) begin
				case (reg_index_t'(cfg_index))
					REG_ENABLE:    enabled   = cfg_data[0];
					REG_STEREO:    stereo_on = cfg_data[0];
					REG_CROSSOVER: xover_k   = cfg_data[COEFF_W-1:0];
					REG_ATTACK:    attack_k  = cfg_data[COEFF_W-1:0];
					REG_RELEASE:   release_k = cfg_data[COEFF_W-1:0];
					REG_THRESHOLD: threshold = cfg_data[THRESH_W-1:0];
					REG_SLOPE:     slope     = cfg_data[SLOPE_W-1:0];
					REG_CEILING:   ceil_mag  = cfg_data[CEIL_W-1:0];
					default: ;
				endcase
			end
			if (sample_ch.valid && sample_ch.ready) begin
				if (sample_ch.block_start) begin
					for (int c = 0; c < CHANNELS; c++) begin
						low_band[c]  = 0;
						env_level[c] = 0;
					end
				end
				want.left  = sample_ch.sample_left;
				want.right = sample_ch.sample_right;
				if (enabled) begin
					want.left = compress_channel(sample_ch.sample_left, 0);
					if (stereo_on && CHANNELS > 1)
						want.right = compress_channel(sample_ch.sample_right, 1);
				end
				expected_pairs.push_back(want);
			end
			if (result_ch.valid && result_ch.ready) begin
				got.left  = result_ch.out_left;
				got.right = result_ch.out_right;
				if (expected_pairs.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got %0d / %0d",
						$time, got.left, got.right);
				end else begin
					want = expected_pairs.pop_front();
					if (got.left !== want.left) begin
						mismatches++;
						$display("%0t: out_left expected %0d, got %0d",
							$time, want.left, got.left);
					end
					if (got.right !== want.right) begin
						mismatches++;
						$display("%0t: out_right expected %0d, got %0d",
							$time, want.right, got.right);
					end
				end
			end
			outstanding = expected_pairs.size();
		end
	end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Crossover upward compressor: top-level test
// Drives stereo sample requests and register settings into the core with
// random idling on both sides, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cuc_pkg::*;

	localparam sample_t PEAK   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t TROUGH = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct {
		logic                en;
		logic                st;
		logic [COEFF_W-1:0]  xover;
		logic [COEFF_W-1:0]  attack;
		logic [COEFF_W-1:0]  rel;
		logic [THRESH_W-1:0] thresh;
		logic [SLOPE_W-1:0]  slope;
		logic [CEIL_W-1:0]   ceil_mag;
	} settings_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	bit                     calm;
	int                     mismatches;
	int                     outstanding;
	int                     pairs_sent;
	int                     starts_sent;
	int                     settings_used;

	cuc_sample_if sample_ch();
	cuc_result_if result_ch();

	crossover_upward_compressor_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_ch    (sample_ch),
		.result_ch    (result_ch)
	);

	compressor_checker check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_ch    (sample_ch),
		.result_ch    (result_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int hold;
		result_ch.ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				hold--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				hold = $urandom_range(0, 16);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_pair(sample_t l, sample_t r, logic bs);
		if (!calm && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.sample_left  <= l;
		sample_ch.sample_right <= r;
		sample_ch.block_start  <= bs;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
		pairs_sent++;
		if (bs)
			starts_sent++;
	endtask

	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic apply_settings(settings_t s);
		reg_index_t            idx;
		logic [CFG_DATA_W-1:0] value;
		logic [CFG_DATA_W-1:0] keep;
		int                    w;
		settle();
		idx = idx.first();
		repeat (idx.num()) begin
			case (idx)
				REG_ENABLE:    begin value = CFG_DATA_W'(s.en);       w = 1;        end
				REG_STEREO:    begin value = CFG_DATA_W'(s.st);       w = 1;        end
				REG_CROSSOVER: begin value = CFG_DATA_W'(s.xover);    w = COEFF_W;  end
				REG_ATTACK:    begin value = CFG_DATA_W'(s.attack);   w = COEFF_W;  end
				REG_RELEASE:   begin value = CFG_DATA_W'(s.rel);      w = COEFF_W;  end
				REG_THRESHOLD: begin value = CFG_DATA_W'(s.thresh);   w = THRESH_W; end
				REG_SLOPE:     begin value = CFG_DATA_W'(s.slope);    w = SLOPE_W;  end
				default:       begin value = CFG_DATA_W'(s.ceil_mag); w = CEIL_W;   end
			endcase
			keep = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
			cfg_write_en <= 1'b1;
			cfg_index    <= idx;
			cfg_data     <= (CFG_DATA_W'($urandom) & ~keep) | value;
			@(negedge clk);
			idx = idx.next();
		end
		cfg_write_en <= 1'b0;
		settings_used++;
	endtask

	function automatic settings_t typical();
		settings_t s;
		s.en       = 1'b1;
		s.st       = 1'b1;
		s.xover    = RST_CROSSOVER;
		s.attack   = RST_ATTACK;
		s.rel      = RST_RELEASE;
		s.thresh   = RST_THRESHOLD;
		s.slope    = SLOPE_W'(9830400);
		s.ceil_mag = RST_CEILING;
		return s;
	endfunction

	function automatic logic [COEFF_W-1:0] pick_coeff();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return COEFF_W'(1) << COEFF_FRAC;
			2:       return COEFF_W'($urandom);
			default: return COEFF_W'($urandom_range(0, 1 << COEFF_FRAC));
		endcase
	endfunction

	function automatic settings_t random_settings();
		settings_t s;
		s.en       = 1'b1;
		s.st       = $urandom_range(0, 3) != 0;
		s.xover    = pick_coeff();
		s.attack   = pick_coeff();
		s.rel      = pick_coeff();
		s.thresh   = $urandom_range(0, 1) ? THRESH_W'($urandom)
			: THRESH_W'($urandom_range(0, 1 << 20));
		s.slope    = ($urandom_range(0, 3) == 0) ? SLOPE_W'($urandom)
			: SLOPE_W'($urandom_range(0, 9830400));
		s.ceil_mag = ($urandom_range(0, 3) == 0) ? '1 : CEIL_W'($urandom);
		return s;
	endfunction

	function automatic sample_t noise_sample(int bits);
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(0, 1) ? PEAK : TROUGH;
		if (bits >= SAMPLE_BITS - 1)
			return sample_t'($urandom);
		return sample_t'(int'($urandom_range(0, (2 << bits) - 1)) - (1 << bits));
	endfunction

	task automatic stream_samples(int count, bit quiet_end);
		int seg_left;
		int bits;
		seg_left = 0;
		bits     = SAMPLE_BITS - 1;
		for (int i = 0; i < count; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(8, 40);
				case ($urandom_range(0, 4))
					0:       bits = SAMPLE_BITS - 1;
					1:       bits = 16;
					2:       bits = 12;
					3:       bits = 8;
					default: bits = 3;
				endcase
				calm = quiet_end || ($urandom_range(0, 3) == 0);
			end
			seg_left--;
			send_pair(noise_sample(bits), noise_sample(bits), $urandom_range(0, 31) == 0);
		end
	endtask

	initial begin
		settings_t cfg;
		arst_n                 = 1'b0;
		cfg_write_en           = 1'b0;
		cfg_index              = REG_ENABLE;
		cfg_data               = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.sample_left  = '0;
		sample_ch.sample_right = '0;
		sample_ch.block_start  = 1'b0;
		calm                   = 1'b0;
		pairs_sent             = 0;
		starts_sent            = 0;
		settings_used          = 1;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults leave processing off, so these pass straight through.
		send_pair(PEAK, TROUGH, 1'b0);
		send_pair(TROUGH, PEAK, 1'b1);
		send_pair(-1, 1, 1'b0);

		cfg = typical();
		apply_settings(cfg);
		send_pair(0, 0, 1'b1);
		send_pair(PEAK, PEAK, 1'b0);
		send_pair(TROUGH, TROUGH, 1'b0);
		send_pair(PEAK, TROUGH, 1'b0);
		send_pair(TROUGH, PEAK, 1'b0);
		send_pair(1, -1, 1'b0);
		send_pair(-1, 1, 1'b0);
		send_pair(100, -100, 1'b1);
		send_pair(200, -200, 1'b0);
		send_pair(-300, 300, 1'b0);
		send_pair(50, -50, 1'b0);

		// Left channel only, with the clip closed down to zero.
		cfg.st       = 1'b0;
		cfg.ceil_mag = '0;
		apply_settings(cfg);
		send_pair(PEAK, TROUGH, 1'b0);
		send_pair(TROUGH, PEAK, 1'b0);
		send_pair(12345, -12345, 1'b0);

		// Every coefficient at its widest, so the state saturates.
		cfg.st       = 1'b1;
		cfg.xover    = '1;
		cfg.attack   = '1;
		cfg.rel      = '1;
		cfg.thresh   = '1;
		cfg.slope    = '1;
		cfg.ceil_mag = '1;
		apply_settings(cfg);
		send_pair(PEAK, TROUGH, 1'b0);
		send_pair(TROUGH, PEAK, 1'b0);
		send_pair(PEAK, PEAK, 1'b0);
		send_pair(TROUGH, TROUGH, 1'b0);

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: cfg = typical();
				1: begin
					cfg        = typical();
					cfg.xover  = '0;
					cfg.attack = '0;
					cfg.rel    = '0;
				end
				2: begin
					cfg    = random_settings();
					cfg.en = 1'b0;
				end
				3: begin
					cfg    = random_settings();
					cfg.st = 1'b0;
				end
				4: begin
					cfg        = random_settings();
					cfg.thresh = '0;
				end
				5: begin
					cfg          = typical();
					cfg.thresh   = '1;
					cfg.slope    = '1;
					cfg.ceil_mag = '0;
				end
				9: cfg = typical();
				default: cfg = random_settings();
			endcase
			apply_settings(cfg);
			stream_samples($urandom_range(75, 95), p == 9);
		end

		settle();
		repeat (20) @(negedge clk);
		$display("Covered %0d sample pairs, %0d with a block start, under %0d register settings.",
			pairs_sent, starts_sent, settings_used);
		$display("Checked %0d results with %0d mismatches.", pairs_sent - outstanding, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
